>>> hdl/tsp_pkg.sv
// Shared types and constants of the tag-length-value stream parser.
package tsp_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int TAG_W       = 32;
	localparam int BYTE_W      = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_TAG_SIZE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEN_SIZE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAG_COUNT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAG_ENTRY0 = 3'd3;

	// Largest tag or length field in bytes.
	localparam logic [2:0] MAX_FIELD_BYTES = 3'd4;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_VAL  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0] tag_size;
		logic [2:0] len_size;
		logic [2:0] tag_count;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0]  matched_tag;
		logic [31:0]       record_length;
		logic [BYTE_W-1:0] value_byte;
		logic              byte_present;
		logic              record_last;
	} out_item_t;

endpackage

>>> hdl/tsp_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface tsp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/tsp_front.sv
// Front end: tag hunting, length gathering and value byte classification.
module tsp_front #(
	parameter int TAG_ENTRIES = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tsp_pkg::cfg_t             cfg,
	input  logic [tsp_pkg::TAG_W-1:0] tag_entry [TAG_ENTRIES],
	input  logic                      take,
	input  logic [7:0]                in_byte,
	output logic                      push,
	output tsp_pkg::out_item_t        result
);

	localparam logic [2:0] ENTRIES_C = 3'(TAG_ENTRIES);

	tsp_pkg::phase_t phase_q, phase_d;
	logic [31:0] win_q, win_d;
	logic [2:0]  tfill_q, tfill_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  lfill_q, lfill_d;
	logic [31:0] vcnt_q, vcnt_d;

	logic [2:0]  tsz, lsz, cnt;
	logic [31:0] new_win, cand, mask, acc_new, vcnt_inc;
	logic [2:0]  lfill_inc;
	logic        hit;

	always_comb begin
		tsz = (cfg.tag_size == 3'd0) ? 3'd1 :
			(cfg.tag_size > tsp_pkg::MAX_FIELD_BYTES) ? tsp_pkg::MAX_FIELD_BYTES : cfg.tag_size;
		lsz = (cfg.len_size == 3'd0) ? 3'd1 :
			(cfg.len_size > tsp_pkg::MAX_FIELD_BYTES) ? tsp_pkg::MAX_FIELD_BYTES : cfg.len_size;
		cnt = (cfg.tag_count > ENTRIES_C) ? ENTRIES_C : cfg.tag_count;
	end

	// The candidate is the newest tag_size bytes, oldest of them in the low bits.
	always_comb begin
		new_win = {in_byte, win_q[31:8]};
		case (tsz)
			3'd1: begin
				cand = {24'd0, new_win[31:24]};
				mask = 32'h0000_00FF;
			end
			3'd2: begin
				cand = {16'd0, new_win[31:16]};
				mask = 32'h0000_FFFF;
			end
			3'd3: begin
				cand = {8'd0, new_win[31:8]};
				mask = 32'h00FF_FFFF;
			end
			default: begin
				cand = new_win;
				mask = 32'hFFFF_FFFF;
			end
		endcase
		hit = 1'b0;
		for (int i = 0; i < TAG_ENTRIES; i++) begin
			if ((3'(i) < cnt) && ((tag_entry[i] & mask) == cand)) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		acc_new   = acc_q | ({24'd0, in_byte} << {lfill_q[1:0], 3'b000});
		lfill_inc = lfill_q + 3'd1;
		vcnt_inc  = vcnt_q + 32'd1;
	end

	always_comb begin
		phase_d = phase_q;
		win_d   = win_q;
		tfill_d = tfill_q;
		acc_d   = acc_q;
		lfill_d = lfill_q;
		vcnt_d  = vcnt_q;
		push    = 1'b0;
		result  = '0;
		if (take) begin
			case (phase_q)
				tsp_pkg::PH_LEN: begin
					acc_d   = acc_new;
					lfill_d = lfill_inc;
					if (lfill_inc >= lsz) begin
						lfill_d = 3'd0;
						vcnt_d  = 32'd0;
						if (acc_new == 32'd0) begin
							phase_d             = tsp_pkg::PH_HUNT;
							push                = 1'b1;
							result.matched_tag  = win_q;
							result.record_last  = 1'b1;
						end else begin
							phase_d = tsp_pkg::PH_VAL;
						end
					end
				end
				tsp_pkg::PH_VAL: begin
					push                 = 1'b1;
					result.matched_tag   = win_q;
					result.record_length = acc_q;
					result.value_byte    = in_byte;
					result.byte_present  = 1'b1;
					result.record_last   = (vcnt_inc >= acc_q);
					if (vcnt_inc >= acc_q) begin
						phase_d = tsp_pkg::PH_HUNT;
						vcnt_d  = 32'd0;
					end else begin
						vcnt_d = vcnt_inc;
					end
				end
				default: begin
					phase_d = tsp_pkg::PH_HUNT;
					win_d   = new_win;
					if (tfill_q < tsp_pkg::MAX_FIELD_BYTES) begin
						tfill_d = tfill_q + 3'd1;
					end
					if ((tfill_d >= tsz) && hit) begin
						win_d   = cand;
						tfill_d = 3'd0;
						acc_d   = 32'd0;
						lfill_d = 3'd0;
						phase_d = tsp_pkg::PH_LEN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsp_pkg::PH_HUNT;
			win_q   <= '0;
			tfill_q <= '0;
			acc_q   <= '0;
			lfill_q <= '0;
			vcnt_q  <= '0;
		end else begin
			phase_q <= phase_d;
			win_q   <= win_d;
			tfill_q <= tfill_d;
			acc_q   <= acc_d;
			lfill_q <= lfill_d;
			vcnt_q  <= vcnt_d;
		end
	end

endmodule

>>> hdl/tsp_queue.sv
// Back end: short result queue whose head drives the result channel.
module tsp_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsp_pkg::out_item_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output tsp_pkg::out_item_t head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	tsp_pkg::out_item_t slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/tlv_stream_parser_top.sv
// Latency: a result is offered on the cycle after the transfer of the byte that causes it
// when no older result waits ahead of it. Throughput: one byte per cycle while the queue
// is not full; the parser state updates once per byte, and the result queue (QUEUE_DEPTH
// entries) takes the output stalls. The input is ready whenever the queue has a free entry.
// Reset: arst_n clears the parser to tag hunting, empties the queue and
// returns every configuration register to its reset value.
module tlv_stream_parser_top #(
	parameter int TAG_ENTRIES = 4,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tsp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data,
	tsp_stream_if.sink                      byte_stream,
	tsp_stream_if.source                    result_stream
);

	// Configuration registers. Writes to an index beyond the table are ignored.
	tsp_pkg::cfg_t             cfg_q;
	logic [tsp_pkg::TAG_W-1:0] tag_entry_q [TAG_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tag_size  <= 3'd2;
			cfg_q.len_size  <= 3'd1;
			cfg_q.tag_count <= 3'd0;
			for (int i = 0; i < TAG_ENTRIES; i++) begin
				tag_entry_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tsp_pkg::CFG_TAG_SIZE:  cfg_q.tag_size  <= cfg_data[2:0];
				tsp_pkg::CFG_LEN_SIZE:  cfg_q.len_size  <= cfg_data[2:0];
				tsp_pkg::CFG_TAG_COUNT: cfg_q.tag_count <= cfg_data[2:0];
				default: ;
			endcase
			for (int i = 0; i < TAG_ENTRIES; i++) begin
				if (cfg_index == tsp_pkg::CFG_TAG_ENTRY0 + tsp_pkg::CFG_INDEX_W'(i)) begin
					tag_entry_q[i] <= cfg_data;
				end
			end
		end
	end

	// A byte is taken whenever the queue can hold the result it may cause.
	// Every byte produces at most one result, so one free entry is enough.
	logic               queue_full;
	logic               take;
	logic               push;
	tsp_pkg::out_item_t front_result;

	assign byte_stream.ready = !queue_full;
	assign take              = byte_stream.valid && !queue_full;

	// The front end holds the whole parsing state: the sliding tag window
	// and its parallel compare against the table, the length accumulator
	// and the count of value bytes passed on for the current record.
	tsp_front #(
		.TAG_ENTRIES (TAG_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.tag_entry (tag_entry_q),
		.take      (take),
		.in_byte   (byte_stream.payload.in_byte),
		.push      (push),
		.result    (front_result)
	);

	// The queue decouples the front end from a stalled consumer, so input
	// transfers carry on while a finished result waits to be taken.
	tsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (front_result),
		.full       (queue_full),
		.pop        (result_stream.ready),
		.head_valid (result_stream.valid),
		.head_data  (result_stream.payload)
	);

endmodule

>>> hdl/tsp_checker.sv
// Port-level assertions for the parser top level and the bind that attaches them.
module tsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] matched_tag,
	input logic [31:0] record_length,
	input logic [7:0]  value_byte,
	input logic        byte_present,
	input logic        record_last
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched_tag)
			&& $stable(record_length) && $stable(value_byte)
			&& $stable(byte_present) && $stable(record_last))
		else $error("stalled result changed");

	// An empty result closes a zero-length record.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present |-> record_last && record_length == 32'd0
			&& value_byte == 8'd0)
		else $error("malformed empty result");

	// A value byte only belongs to a record of non-zero length.
	a_value_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_present |-> record_length != 32'd0)
		else $error("value byte with zero length");

	// With nothing waiting at the output the input must be open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output is empty");

endmodule

bind tlv_stream_parser_top tsp_checker u_tsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (byte_stream.ready),
	.out_valid     (result_stream.valid),
	.out_ready     (result_stream.ready),
	.matched_tag   (result_stream.payload.matched_tag),
	.record_length (result_stream.payload.record_length),
	.value_byte    (result_stream.payload.value_byte),
	.byte_present  (result_stream.payload.byte_present),
	.record_last   (result_stream.payload.record_last)
);

>>> sim/tb_tlv_stream_parser_top.sv
// Self-checking testbench for the tag-length-value stream parser top level.
module tb_tlv_stream_parser_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tsp_pkg::*;

	// Register index that maps to no register; writes to it must be ignored.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int TABLE_SIZE    = 4;
	// Margin that drain waits after the last awaited result has been seen.
	localparam int DRAIN_CYCLES  = 4;
	localparam int HOLD_CYCLES   = 80;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int PHASE_ITEMS   = 150;
	localparam int TIMEOUT_NS    = 400_000;

	// Tracks the parser state and configuration, predicts the results of every
	// byte transfer and checks the result transfers against those predictions.
	class tlv_record_tracker;
		logic [2:0]  tag_size_q;
		logic [2:0]  len_size_q;
		logic [2:0]  tag_count_q;
		logic [31:0] tag_table [TABLE_SIZE];
		phase_t      phase_q;
		logic [31:0] window_q;
		logic [2:0]  tag_fill_q;
		logic [31:0] length_q;
		logic [2:0]  length_fill_q;
		logic [31:0] value_count_q;
		out_item_t   awaited_results [$];
		int unsigned mismatches;

		function new();
			tag_size_q    = 3'd2;
			len_size_q    = 3'd1;
			tag_count_q   = 3'd0;
			foreach (tag_table[i]) tag_table[i] = '0;
			phase_q       = PH_HUNT;
			window_q      = '0;
			tag_fill_q    = '0;
			length_q      = '0;
			length_fill_q = '0;
			value_count_q = '0;
			mismatches    = 0;
		endfunction

		// Sizes of 0 behave as 1 and sizes above 4 behave as 4.
		static function int field_bytes(logic [2:0] s);
			if (s == 3'd0) begin
				return 1;
			end
			if (s > MAX_FIELD_BYTES) begin
				return 4;
			end
			return int'(s);
		endfunction

		function int table_entries();
			return (tag_count_q > 3'd4) ? TABLE_SIZE : int'(tag_count_q);
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_TAG_SIZE: begin
					tag_size_q = data[2:0];
				end
				CFG_LEN_SIZE: begin
					len_size_q = data[2:0];
				end
				CFG_TAG_COUNT: begin
					tag_count_q = data[2:0];
				end
				default: begin
					if (idx >= CFG_TAG_ENTRY0 && idx < CFG_TAG_ENTRY0 + TABLE_SIZE) begin
						tag_table[idx - CFG_TAG_ENTRY0] = data;
					end
				end
			endcase
		endfunction

		function void push_result(logic [7:0] vbyte, logic present, logic last);
			out_item_t r;
			r.matched_tag   = window_q;
			r.record_length = length_q;
			r.value_byte    = vbyte;
			r.byte_present  = present;
			r.record_last   = last;
			awaited_results.push_back(r);
		endfunction

		// Advances the parser by one accepted byte.
		function void accept_byte(logic [7:0] b);
			int          tsz;
			int          lsz;
			logic [31:0] mask;
			logic [31:0] cand;
			logic        last;
			bit          hit;
			tsz = field_bytes(tag_size_q);
			lsz = field_bytes(len_size_q);
			hit = 1'b0;
			case (phase_q)
				PH_LEN: begin
					length_q = length_q | ({24'd0, b} << (8 * length_fill_q[1:0]));
					length_fill_q = length_fill_q + 3'd1;
					if (int'(length_fill_q) >= lsz) begin
						length_fill_q = '0;
						value_count_q = '0;
						if (length_q == '0) begin
							phase_q = PH_HUNT;
							push_result(8'd0, 1'b0, 1'b1);
						end else begin
							phase_q = PH_VAL;
						end
					end
				end
				PH_VAL: begin
					value_count_q = value_count_q + 32'd1;
					last = (value_count_q >= length_q);
					push_result(b, 1'b1, last);
					if (last) begin
						phase_q = PH_HUNT;
						value_count_q = '0;
					end
				end
				default: begin
					// Hunting: the newest byte enters at the top of the window.
					phase_q = PH_HUNT;
					window_q = {b, window_q[31:8]};
					if (tag_fill_q < 3'd4) begin
						tag_fill_q = tag_fill_q + 3'd1;
					end
					if (int'(tag_fill_q) >= tsz) begin
						mask = 32'hFFFF_FFFF >> (8 * (4 - tsz));
						cand = window_q >> (8 * (4 - tsz));
						for (int i = 0; i < table_entries(); i++) begin
							if (!hit && (tag_table[i] & mask) == cand) begin
								hit           = 1'b1;
								window_q      = cand;
								tag_fill_q    = '0;
								length_q      = '0;
								length_fill_q = '0;
								phase_q       = PH_LEN;
							end
						end
					end
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited_results.size() == 0) begin
				$error("result with no prediction: tag %h length %0d byte %h",
					got.matched_tag, got.record_length, got.value_byte);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			if (got.matched_tag !== want.matched_tag) begin
				$error("matched_tag: expected %h, actual %h", want.matched_tag, got.matched_tag);
				mismatches++;
			end
			if (got.record_length !== want.record_length) begin
				$error("record_length: expected %0d, actual %0d",
					want.record_length, got.record_length);
				mismatches++;
			end
			if (got.value_byte !== want.value_byte) begin
				$error("value_byte: expected %h, actual %h", want.value_byte, got.value_byte);
				mismatches++;
			end
			if (got.byte_present !== want.byte_present) begin
				$error("byte_present: expected %b, actual %b", want.byte_present, got.byte_present);
				mismatches++;
			end
			if (got.record_last !== want.record_last) begin
				$error("record_last: expected %b, actual %b", want.record_last, got.record_last);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tsp_stream_if #(.T(in_item_t))  byte_stream ();
	tsp_stream_if #(.T(out_item_t)) result_stream ();

	tlv_record_tracker tracker;

	// Idle rates in percent for each side, changed by the stimulus per phase.
	int unsigned src_idle_pct  = 21;
	int unsigned sink_idle_pct = 21;
	// Asks the result side for one long hold-off.
	bit          hold_req;
	int unsigned items_sent;

	tlv_stream_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.byte_stream   (byte_stream),
		.result_stream (result_stream)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offers one byte, after a random gap, and holds it until the transfer.
	// Every transfer is handed to the tracker at the edge where it happens.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			byte_stream.valid <= 1'b0;
			@(posedge clk);
		end
		byte_stream.valid <= 1'b1;
		byte_stream.payload.in_byte <= b;
		do begin
			@(posedge clk);
		end while (!byte_stream.ready);
		tracker.accept_byte(b);
		items_sent++;
	endtask

	// Stops offering bytes and waits until every predicted result has been
	// seen, then lets the parser settle before any register is touched.
	task automatic drain();
		byte_stream.valid <= 1'b0;
		while (tracker.awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the enable drops again on the next edge so that
	// back-to-back writes never drive the enable twice within one step.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Sends tag, little-endian length and random value bytes of a record built
	// from a table entry, cut off after the given number of bytes.
	task automatic send_record(input int idx, input logic [31:0] len, input int unsigned budget);
		logic [31:0] tag;
		int          tsz;
		int          lsz;
		tag = tracker.tag_table[idx];
		tsz = tracker.field_bytes(tracker.tag_size_q);
		lsz = tracker.field_bytes(tracker.len_size_q);
		for (int k = 0; k < tsz && budget > 0; k++, budget--) begin
			send_byte(tag[8*k +: 8]);
		end
		for (int k = 0; k < lsz && budget > 0; k++, budget--) begin
			send_byte(len[8*k +: 8]);
		end
		for (int unsigned k = 0; k < len && budget > 0; k++, budget--) begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Result side: random back-pressure, one long hold-off on request, and a
	// check of every result transfer.
	initial begin
		result_stream.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stream.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stream.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			@(posedge clk);
			if (result_stream.valid && result_stream.ready) begin
				tracker.check_result(result_stream.payload);
			end
		end
	end

	// Main stimulus: reset, a directed part and then randomised phases, each
	// phase with fresh register settings written while the parser is idle.
	initial begin
		int          phase_no;
		int          ts;
		int          ls;
		int          cnt;
		int          pick;
		int unsigned start;
		int unsigned random_bytes;
		logic [31:0] len;

		tracker = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_TAG_SIZE;
		cfg_data <= '0;
		byte_stream.valid <= 1'b0;
		byte_stream.payload <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset table count of zero every byte is simply dropped.
		send_byte(8'h00);
		send_byte(8'hFF);

		// Two-byte tags whose upper entry bytes must be ignored. A leading junk
		// byte is shed from the window, then one two-byte record and one empty
		// record follow.
		drain();
		write_reg(CFG_TAG_COUNT, 32'd2);
		write_reg(CFG_TAG_ENTRY0, 32'h1234_BEEF);
		write_reg(CFG_TAG_ENTRY0 + 3'd1, 32'hFFFF_FF00);
		send_byte(8'h11);
		send_byte(8'hEF);
		send_byte(8'hBE);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);

		// Tag size zero behaves as one byte, a table count above the table
		// size is capped and the upper bits of the size data are discarded.
		// The length field is shrunk from four bytes to one halfway through,
		// so the length completes on the very next byte.
		drain();
		write_reg(CFG_TAG_SIZE, 32'hFFFF_FFF8);
		write_reg(CFG_LEN_SIZE, 32'h0000_0004);
		write_reg(CFG_TAG_COUNT, 32'h0000_0007);
		write_reg(CFG_TAG_ENTRY0 + 3'd2, 32'hC3C3_C3A5);
		write_reg(CFG_TAG_ENTRY0 + 3'd3, 32'h0000_005A);
		send_byte(8'hA5);
		send_byte(8'h01);
		send_byte(8'h00);
		drain();
		write_reg(CFG_LEN_SIZE, 32'h0000_0001);
		send_byte(8'h00);
		send_byte(8'h5A);

		// Writes to the unused index change nothing. Four-byte tags and a
		// length size above the maximum, which behaves as four bytes.
		drain();
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		write_reg(CFG_TAG_SIZE, 32'd4);
		write_reg(CFG_LEN_SIZE, 32'd7);
		write_reg(CFG_TAG_COUNT, 32'd1);
		write_reg(CFG_TAG_ENTRY0, 32'h4433_2211);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		send_byte(8'h44);
		send_byte(8'h03);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01);

		// Random phases. Sizes step through the legal combinations in turn, now and
		// then replaced by an out-of-range value. Most traffic is well-formed
		// records drawn from the table; the rest is noise and cut-off records.
		phase_no = 0;
		random_bytes = 0;
		while (random_bytes < RANDOM_ITEMS) begin
			drain();
			ts = 1 + (phase_no % 4);
			ls = 1 + ((phase_no + phase_no / 4) % 4);
			if ($urandom_range(0, 5) == 0) begin
				ts = $urandom_range(5, 8) % 8;
			end
			if ($urandom_range(0, 5) == 0) begin
				ls = $urandom_range(5, 8) % 8;
			end
			cnt = (phase_no == 6) ? 0 : $urandom_range(1, 7);
			write_reg(CFG_TAG_SIZE, ($urandom() & ~32'h7) | 32'(ts));
			write_reg(CFG_LEN_SIZE, ($urandom() & ~32'h7) | 32'(ls));
			write_reg(CFG_TAG_COUNT, ($urandom() & ~32'h7) | 32'(cnt));
			for (int e = 0; e < TABLE_SIZE; e++) begin
				write_reg(CFG_TAG_ENTRY0 + 3'(e), $urandom());
			end

			// One phase runs with no idling on either side; in another the
			// result side stalls for a long stretch while bytes keep coming.
			src_idle_pct  = (phase_no == 1 || phase_no == 3) ? 0 : 21;
			sink_idle_pct = (phase_no == 1) ? 0 : 21;
			if (phase_no == 3) begin
				hold_req = 1'b1;
			end

			start = items_sent;
			if (cnt == 0) begin
				// Nothing can match, so these bytes only prove nothing comes out.
				repeat (24) send_byte(8'($urandom_range(0, 255)));
			end else begin
				while (items_sent - start < PHASE_ITEMS) begin
					pick = $urandom_range(0, 99);
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
						: $urandom_range(0, 8);
					if (pick < 15) begin
						repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
					end else if (pick < 20) begin
						send_record($urandom_range(0, tracker.table_entries() - 1), len,
							$urandom_range(1, 6));
					end else begin
						send_record($urandom_range(0, tracker.table_entries() - 1), len,
							32'hFFFF_FFFF);
					end
				end
				random_bytes += items_sent - start;
			end
			phase_no++;
		end

		drain();
		if (tracker.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop in case the handshakes never complete.
	initial begin
		#TIMEOUT_NS;
		$display("FAILURE");
		$finish;
	end

endmodule
